>>> rtl/hcp_pkg.sv
`timescale 1ns / 1ps

package hcp_pkg;

	typedef enum logic [2:0] {
		PH_KEYWORD = 3'd0,
		PH_USER    = 3'd1,
		PH_PASS    = 3'd2,
		PH_CR      = 3'd3,
		PH_DONE    = 3'd4,
		PH_BAD     = 3'd5
	} phase_t;

	localparam int unsigned KW_LEN = 5;

	localparam logic [7:0] CH_BAR = 8'h7C;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_H   = 8'h48;
	localparam logic [7:0] CH_E   = 8'h45;
	localparam logic [7:0] CH_L   = 8'h4C;
	localparam logic [7:0] CH_O   = 8'h4F;

	// Results caused by one input byte: a first result and an optional
	// second one, which always carries a character.
	typedef struct packed {
		logic [2:0] status;
		logic       two;
		logic       cv0;
		logic       cf0;
		logic [7:0] v0;
		logic       cf1;
		logic [7:0] v1;
	} hcp_pair_t;

	function automatic logic [7:0] kw_char(input logic [2:0] idx);
		logic [7:0] ch;
		case (idx)
			3'd0: ch = CH_H;
			3'd1: ch = CH_E;
			3'd2: ch = CH_L;
			3'd3: ch = CH_L;
			3'd4: ch = CH_O;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

>>> rtl/hcp_core.sv
`timescale 1ns / 1ps

module hcp_core #(
	parameter int MAX_LEN = 255
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  logic [7:0]         in_byte,
	output hcp_pkg::hcp_pair_t pair
);
	import hcp_pkg::*;

	localparam int POS_W = ($clog2(MAX_LEN + 1) > 3) ? $clog2(MAX_LEN + 1) : 3;
	localparam logic [POS_W:0] MAX_X = (POS_W + 1)'(MAX_LEN);

	phase_t           phase_q, phase_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic             rf_q, rf_d;
	logic             fld;
	logic             room1, room2;
	logic             emit0, emit1;
	logic             f0, f1;
	logic [7:0]       v0, v1;
	logic [POS_W:0]   pos_x;

	assign pos_x = {1'b0, pos_q};
	assign room1 = pos_x < MAX_X;
	assign room2 = (pos_x + (POS_W + 1)'(2)) <= MAX_X;
	assign fld   = (phase_q == PH_PASS);

	always_comb begin
		phase_d = phase_q;
		pos_d   = pos_q;
		rf_d    = rf_q;
		emit0   = 1'b0;
		emit1   = 1'b0;
		f0      = 1'b0;
		v0      = 8'h00;
		f1      = 1'b0;
		v1      = 8'h00;
		case (phase_q)
			PH_KEYWORD: begin
				if (pos_q >= POS_W'(KW_LEN)) begin
					if (in_byte == CH_BAR) begin
						phase_d = PH_USER;
						pos_d   = '0;
					end else begin
						phase_d = PH_BAD;
					end
				end else if (in_byte == kw_char(pos_q[2:0])) begin
					pos_d = pos_q + POS_W'(1);
				end else begin
					phase_d = PH_BAD;
				end
			end
			PH_USER, PH_PASS: begin
				if (in_byte == CH_BAR) begin
					if (!fld && pos_q != '0) begin
						phase_d = PH_PASS;
						pos_d   = '0;
					end else begin
						phase_d = PH_BAD;
					end
				end else if (in_byte == CH_CR) begin
					rf_d    = fld;
					phase_d = PH_CR;
				end else if (!room1) begin
					phase_d = PH_BAD;
				end else begin
					emit0 = 1'b1;
					f0    = fld;
					v0    = in_byte;
					pos_d = pos_q + POS_W'(1);
				end
			end
			PH_CR: begin
				if (in_byte == CH_LF) begin
					if (rf_q && pos_q != '0) begin
						phase_d = PH_DONE;
					end else begin
						phase_d = PH_BAD;
					end
				end else if (in_byte == CH_CR) begin
					if (!room1) begin
						phase_d = PH_BAD;
					end else begin
						emit0 = 1'b1;
						f0    = rf_q;
						v0    = CH_CR;
						pos_d = pos_q + POS_W'(1);
					end
				end else if (in_byte == CH_BAR) begin
					if (!rf_q && room1) begin
						emit0   = 1'b1;
						v0      = CH_CR;
						phase_d = PH_PASS;
						pos_d   = '0;
					end else begin
						phase_d = PH_BAD;
					end
				end else if (!room2) begin
					phase_d = PH_BAD;
				end else begin
					emit0   = 1'b1;
					f0      = rf_q;
					v0      = CH_CR;
					emit1   = 1'b1;
					f1      = rf_q;
					v1      = in_byte;
					pos_d   = pos_q + POS_W'(2);
					phase_d = rf_q ? PH_PASS : PH_USER;
				end
			end
			PH_DONE: begin
			end
			default: begin
				phase_d = PH_BAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_KEYWORD;
			pos_q   <= '0;
			rf_q    <= 1'b0;
		end else if (take) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			rf_q    <= rf_d;
		end
	end

	assign pair.status = phase_d;
	assign pair.two    = emit1;
	assign pair.cv0    = emit0;
	assign pair.cf0    = f0;
	assign pair.v0     = v0;
	assign pair.cf1    = f1;
	assign pair.v1     = v1;

endmodule

>>> rtl/hello_credentials_parser.sv
`timescale 1ns / 1ps
// Parser for the HELLO|username|password CR LF greeting, one byte per transaction.
// The input channel (in_valid, in_stall, in_byte) takes one message byte per
// transaction. For each byte the output channel (out_valid, out_stall) gives
// one or two result transactions: the phase after the byte, a captured field
// character if there is one, and last on the final result of that byte.
// Two results arise only when a held-back carriage return is released together
// with the data byte that follows it.
// The results of an accepted byte are registered into the result queue and
// shown once all earlier results are taken. A byte is accepted in every
// cycle while the receiver takes results and the queue has room; a byte with
// two results holds the output until both are taken. The rate is set by the
// two-entry result queue, which stalls the input only when both entries are full.
// When the receiver stalls, the shown result holds and the queue fills; the
// input is then stalled until an entry frees up.
// Reset empties the queue and returns the parser to keyword matching, with
// the field length count and the held-return field cleared.
// Finished and invalid persist until reset.

module hello_credentials_parser #(
	parameter int MAX_LEN = 255
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] status,
	output logic       char_valid,
	output logic       char_field,
	output logic [7:0] char_value,
	output logic       last
);
	import hcp_pkg::*;

	hcp_pair_t  pair;
	hcp_pair_t  slot0_q, slot1_q, head;
	logic       wr_q, rd_q, sub_q;
	logic [1:0] cnt_q;
	logic       take, pop, head_last, done;

	assign take      = in_valid && !in_stall;
	assign in_stall  = (cnt_q == 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign pop       = out_valid && !out_stall;
	assign head      = rd_q ? slot1_q : slot0_q;
	assign head_last = !head.two || sub_q;
	assign done      = pop && head_last;

	hcp_core #(
		.MAX_LEN(MAX_LEN)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.in_byte(in_byte),
		.pair   (pair)
	);

	always_ff @(posedge clk) begin
		if (take && !wr_q) begin
			slot0_q <= pair;
		end
		if (take && wr_q) begin
			slot1_q <= pair;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			sub_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (take) begin
				wr_q <= !wr_q;
			end
			if (done) begin
				rd_q  <= !rd_q;
				sub_q <= 1'b0;
			end else if (pop) begin
				sub_q <= 1'b1;
			end
			cnt_q <= cnt_q + {1'b0, take} - {1'b0, done};
		end
	end

	assign status     = head.status;
	assign char_valid = sub_q ? 1'b1 : head.cv0;
	assign char_field = sub_q ? head.cf1 : head.cf0;
	assign char_value = sub_q ? head.v1 : head.v0;
	assign last       = head_last;

endmodule

>>> rtl/hcp_checker.sv
`timescale 1ns / 1ps

module hcp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] status,
	input logic       char_valid,
	input logic       char_field,
	input logic [7:0] char_value,
	input logic       last
);
	import hcp_pkg::*;

	// A stalled result transaction keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid &&
			$stable({status, char_valid, char_field, char_value, last}))
		else $error("stalled result changed");

	// A result without a character carries zeros and closes its byte.
	a_no_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !char_valid |-> char_field == 1'b0 && char_value == 8'h00 && last)
		else $error("empty result malformed");

	// Finished and invalid never come with a captured character.
	a_end_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == PH_DONE || status == PH_BAD) |-> !char_valid)
		else $error("character emitted in a terminal phase");

	// The first of two results is a released return inside a field.
	a_pair_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> char_valid && char_value == CH_CR &&
			(status == PH_USER || status == PH_PASS))
		else $error("first of two results malformed");

	// The input is never held off while the output side is empty.
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with no pending result");

endmodule

bind hello_credentials_parser hcp_checker u_hcp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.status    (status),
	.char_valid(char_valid),
	.char_field(char_field),
	.char_value(char_value),
	.last      (last)
);

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
	import hcp_pkg::*;

	localparam int FIELD_MAX = 255;
	localparam logic [39:0] KEYWORD = {CH_H, CH_E, CH_L, CH_L, CH_O};

	typedef struct packed {
		logic [2:0] status;
		logic       cv;
		logic       cf;
		logic [7:0] value;
		logic       last;
	} result_t;

	typedef enum int {
		END_OK,
		END_USER_LONG,
		END_PASS_LONG,
		END_BAR_AFTER_PASS,
		END_CR_BAR_PASS,
		END_NO_PASS,
		END_NO_USER,
		END_BAD_KEYWORD,
		END_EMPTY_PASS,
		END_CR_PAIR_LONG
	} ending_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [2:0] status;
	logic       char_valid;
	logic       char_field;
	logic [7:0] char_value;
	logic       last;

	logic [7:0]  byte_queue [$];
	result_t     expected_results [$];
	phase_t      parse_phase = PH_KEYWORD;
	int unsigned field_len = 0;
	logic        cr_field = 1'b0;
	int unsigned gen_count;
	logic        byte_taken = 1'b0;
	logic        result_taken = 1'b0;
	logic        long_hold = 1'b0;
	int          gap_left = 0;
	int          stall_left = 0;
	int          results_seen = 0;
	int          mismatches = 0;

	hello_credentials_parser #(
		.MAX_LEN(FIELD_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.char_valid(char_valid),
		.char_field(char_field),
		.char_value(char_value),
		.last(last)
	);

	always #2 clk = ~clk;

	function automatic int idle_cycles();
		if ($urandom_range(0, 2) == 0)
			return int'($urandom_range(0, 14));
		return 0;
	endfunction

	function automatic logic [7:0] field_char(input logic after_cr);
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (c == CH_BAR || c == CH_CR || (after_cr && c == CH_LF));
		return c;
	endfunction

	// Appends field bytes until the field holds the target number of characters,
	// mixing in held carriage returns that are released as data.
	task automatic fill_field(input int unsigned target);
		while (gen_count < target) begin
			if (target - gen_count >= 3 && $urandom_range(0, 19) == 0) begin
				byte_queue.push_back(CH_CR);
				byte_queue.push_back(CH_CR);
				byte_queue.push_back(field_char(1'b1));
				gen_count += 3;
			end else if (target - gen_count >= 2 && $urandom_range(0, 9) == 0) begin
				byte_queue.push_back(CH_CR);
				byte_queue.push_back(field_char(1'b1));
				gen_count += 2;
			end else begin
				byte_queue.push_back(field_char(1'b0));
				gen_count++;
			end
		end
	endtask

	// The field is full: every one of these continuations must be rejected.
	task automatic overrun_field();
		case ($urandom_range(0, 3))
			0: byte_queue.push_back(field_char(1'b0));
			1: begin
				byte_queue.push_back(CH_CR);
				byte_queue.push_back(field_char(1'b1));
			end
			2: begin
				byte_queue.push_back(CH_CR);
				byte_queue.push_back(CH_CR);
			end
			default: begin
				byte_queue.push_back(CH_CR);
				byte_queue.push_back(CH_BAR);
			end
		endcase
	endtask

	function automatic int unsigned field_target();
		if ($urandom_range(0, 3) == 0)
			return FIELD_MAX;
		return $urandom_range(FIELD_MAX / 2, FIELD_MAX);
	endfunction

	function automatic void parse_byte(input logic [7:0] c);
		logic       fld;
		int         n;
		logic [7:0] val [2];
		logic       fl [2];
		n = 0;
		fld = (parse_phase == PH_PASS);
		case (parse_phase)
			PH_KEYWORD: begin
				if (field_len >= KW_LEN) begin
					if (c == CH_BAR) begin
						parse_phase = PH_USER;
						field_len = 0;
					end else begin
						parse_phase = PH_BAD;
					end
				end else if (c == KEYWORD[39 - 8 * field_len -: 8]) begin
					field_len++;
				end else begin
					parse_phase = PH_BAD;
				end
			end
			PH_USER, PH_PASS: begin
				if (c == CH_BAR) begin
					if (!fld && field_len != 0) begin
						parse_phase = PH_PASS;
						field_len = 0;
					end else begin
						parse_phase = PH_BAD;
					end
				end else if (c == CH_CR) begin
					cr_field = fld;
					parse_phase = PH_CR;
				end else if (field_len >= FIELD_MAX) begin
					parse_phase = PH_BAD;
				end else begin
					fl[0] = fld;
					val[0] = c;
					n = 1;
					field_len++;
				end
			end
			PH_CR: begin
				if (c == CH_LF) begin
					parse_phase = (cr_field && field_len != 0) ? PH_DONE : PH_BAD;
				end else if (c == CH_CR) begin
					if (field_len >= FIELD_MAX) begin
						parse_phase = PH_BAD;
					end else begin
						fl[0] = cr_field;
						val[0] = CH_CR;
						n = 1;
						field_len++;
					end
				end else if (c == CH_BAR) begin
					if (!cr_field && field_len < FIELD_MAX) begin
						fl[0] = 1'b0;
						val[0] = CH_CR;
						n = 1;
						parse_phase = PH_PASS;
						field_len = 0;
					end else begin
						parse_phase = PH_BAD;
					end
				end else if (field_len + 2 > FIELD_MAX) begin
					parse_phase = PH_BAD;
				end else begin
					fl[0] = cr_field;
					fl[1] = cr_field;
					val[0] = CH_CR;
					val[1] = c;
					n = 2;
					field_len += 2;
					parse_phase = cr_field ? PH_PASS : PH_USER;
				end
			end
			PH_DONE: begin
			end
			default: parse_phase = PH_BAD;
		endcase
		if (n == 0)
			expected_results.push_back({parse_phase, 1'b0, 1'b0, 8'h00, 1'b1});
		for (int k = 0; k < n; k++)
			expected_results.push_back({parse_phase, 1'b1, fl[k], val[k], k == n - 1});
	endfunction

	always @(posedge clk) begin : score
		result_t seen;
		result_t want;
		byte_taken <= arst_n && in_valid && !in_stall;
		result_taken <= arst_n && out_valid && !out_stall;
		if (arst_n && in_valid && !in_stall)
			parse_byte(in_byte);
		if (arst_n && out_valid && !out_stall) begin
			seen = {status, char_valid, char_field, char_value, last};
			results_seen++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("tb: unexpected result status=%0d cv=%0b cf=%0b value=%h last=%0b",
						seen.status, seen.cv, seen.cf, seen.value, seen.last);
			end else begin
				want = expected_results.pop_front();
				if (seen.status !== want.status || seen.cv !== want.cv
						|| seen.cf !== want.cf || seen.value !== want.value
						|| seen.last !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("tb: mismatch at result %0d: expected status=%0d cv=%0b ",
							results_seen, want.status, want.cv,
							"cf=%0b value=%h last=%0b, got status=%0d cv=%0b cf=%0b ",
							want.cf, want.value, want.last,
							seen.status, seen.cv, seen.cf,
							"value=%h last=%0b", seen.value, seen.last);
				end
			end
		end
	end

	always @(negedge clk) begin : drive
		logic       nv;
		logic [7:0] nb;
		nv = in_valid;
		nb = in_byte;
		if (arst_n && (!in_valid || byte_taken)) begin
			nv = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (byte_queue.size() != 0) begin
				nb = byte_queue.pop_front();
				nv = 1'b1;
				gap_left = idle_cycles();
			end
		end
		in_valid <= nv;
		in_byte <= nb;
	end

	always @(negedge clk) begin : receive
		if (result_taken)
			stall_left = idle_cycles();
		else if (stall_left > 0)
			stall_left--;
		out_stall <= long_hold || stall_left > 0;
	end

	// A long hold on the result side lets the result queue fill up so that
	// the input side has to stall while bytes are still on offer.
	initial begin : hold_results
		while (results_seen < 100)
			@(negedge clk);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (100)
			@(posedge clk);
		long_hold <= 1'b0;
	end

	initial begin : timeout
		#2000000;
		$display("tb: errors");
		$finish;
	end

	initial begin : stimulus
		ending_t     ending;
		int unsigned r;
		int unsigned cut;
		logic [7:0]  b;
		logic [47:0] greeting;
		r = $urandom_range(0, 15);
		ending = (r < 7) ? END_OK : ending_t'(r - 6);
		greeting = {KEYWORD, CH_BAR};
		cut = $urandom_range(0, 5);
		for (int i = 0; i < 6; i++) begin
			b = greeting[47 - 8 * i -: 8];
			if (ending == END_BAD_KEYWORD && i == cut)
				b = b ^ 8'($urandom_range(1, 255));
			byte_queue.push_back(b);
		end
		if (ending == END_NO_USER) begin
			byte_queue.push_back(CH_BAR);
		end else if (ending != END_BAD_KEYWORD) begin
			// Extreme bytes, a plain LF and both kinds of released carriage return.
			byte_queue.push_back(8'h00);
			byte_queue.push_back(8'hFF);
			byte_queue.push_back(CH_LF);
			byte_queue.push_back(CH_CR);
			byte_queue.push_back(8'h61);
			byte_queue.push_back(CH_CR);
			byte_queue.push_back(CH_CR);
			byte_queue.push_back(8'h62);
			gen_count = 8;
			case (ending)
				END_USER_LONG: begin
					fill_field(FIELD_MAX);
					overrun_field();
				end
				END_CR_PAIR_LONG: begin
					fill_field(FIELD_MAX - 1);
					byte_queue.push_back(CH_CR);
					byte_queue.push_back(field_char(1'b1));
				end
				END_NO_PASS: begin
					fill_field(field_target());
					byte_queue.push_back(CH_CR);
					byte_queue.push_back(CH_LF);
				end
				default: begin
					if ($urandom_range(0, 1) == 0) begin
						fill_field(field_target() - 1);
						byte_queue.push_back(CH_CR);
					end else begin
						fill_field(field_target());
					end
					byte_queue.push_back(CH_BAR);
					gen_count = 0;
					case (ending)
						END_EMPTY_PASS: begin
							byte_queue.push_back(CH_CR);
							byte_queue.push_back(CH_LF);
						end
						END_BAR_AFTER_PASS: begin
							fill_field($urandom_range(0, 20));
							byte_queue.push_back(CH_BAR);
						end
						END_CR_BAR_PASS: begin
							fill_field($urandom_range(0, 20));
							byte_queue.push_back(CH_CR);
							byte_queue.push_back(CH_BAR);
						end
						END_PASS_LONG: begin
							fill_field(FIELD_MAX);
							overrun_field();
						end
						default: begin
							fill_field(field_target());
							byte_queue.push_back(CH_CR);
							byte_queue.push_back(CH_LF);
						end
					endcase
				end
			endcase
		end
		// Once finished or invalid, the parser must keep ignoring whatever arrives.
		repeat (10)
			byte_queue.push_back(CH_LF);
		while (byte_queue.size() < 560)
			byte_queue.push_back(8'($urandom_range(0, 255)));

		repeat (6)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (byte_queue.size() != 0 || in_valid)
			@(negedge clk);
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (20)
			@(negedge clk);
		if (mismatches == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/hcp_pkg.sv
rtl/hcp_core.sv
rtl/hello_credentials_parser.sv
rtl/hcp_checker.sv
test/tb.sv
